>>> rtl/core/mf3_pkg.sv
// shared constants, types and helpers of the 3x3 median filter
package mf3_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int PIXEL_BITS    = 8;
   localparam int COL_BITS      = 10;
   localparam int ROW_BITS      = 10;
   localparam int DIM_BITS      = 11;
   localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
   localparam int LINE_BITS     = 2 * PIXEL_BITS;
   localparam int WIN_SIZE      = 9;
   localparam int RANK_BITS     = $clog2(WIN_SIZE + 1);
   localparam int MAX_RESULTS   = 4;
   localparam int SEL_BITS      = $clog2(MAX_RESULTS);
   localparam int OUTQ_DEPTH    = 8;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);
   localparam int CSR_DATA_BITS = 32;
   localparam int PADDR_BITS    = 3;
   localparam int REG_IDX_BITS  = 1;

   // register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 1'b0;
   localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 1'b1;

   // results one pixel can release, in raster order
   localparam logic [SEL_BITS-1:0] RES_UP_LEFT = 2'd0;
   localparam logic [SEL_BITS-1:0] RES_UP      = 2'd1;
   localparam logic [SEL_BITS-1:0] RES_LEFT    = 2'd2;
   localparam logic [SEL_BITS-1:0] RES_HERE    = 2'd3;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
   } dims_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                last;
      logic                eof;
   } tag_type;

   typedef struct packed {
      pixel_type [WIN_SIZE-1:0] vals;
      logic [WIN_SIZE-1:0]      mask;
      tag_type                  tag;
   } job_type;

   typedef struct packed {
      pixel_type median;
      tag_type   tag;
   } result_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] maxv);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [RANK_BITS-1:0] count_ones(input logic [WIN_SIZE-1:0] bits);
      logic [RANK_BITS-1:0] n;
      n = '0;
      for (int k = 0; k < WIN_SIZE; k++) begin
         n = n + RANK_BITS'(bits[k]);
      end
      return n;
   endfunction

endpackage

>>> rtl/core/mf3_ram.sv
// generic single-port-write, registered-read ram
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mf3_csr.sv
// apb register file holding image width and height
module mf3_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mf3_pkg::PADDR_BITS-1:0]     paddr,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [mf3_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output mf3_pkg::dims_type                  dims
);

   logic [mf3_pkg::DIM_BITS-1:0]     width_ff, width_in;
   logic [mf3_pkg::DIM_BITS-1:0]     height_ff, height_in;
   logic [mf3_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                             wr_en;

   assign reg_idx = paddr[mf3_pkg::PADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_idx)
            mf3_pkg::REG_WIDTH:  width_in  = pwdata[mf3_pkg::DIM_BITS-1:0];
            mf3_pkg::REG_HEIGHT: height_in = pwdata[mf3_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mf3_pkg::REG_WIDTH:  prdata = mf3_pkg::CSR_DATA_BITS'(width_ff);
         mf3_pkg::REG_HEIGHT: prdata = mf3_pkg::CSR_DATA_BITS'(height_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::DIM_BITS'(mf3_pkg::MAX_WIDTH);
         height_ff <= mf3_pkg::DIM_BITS'(mf3_pkg::MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign dims.width  = width_ff;
   assign dims.height = height_ff;

endmodule

>>> rtl/core/mf3_frontend.sv
// position counters, line store read-modify-write, 3x3 window and result sequencer
module mf3_frontend (
   input  logic                  clock,
   input  logic                  reset,
   input  mf3_pkg::dims_type     dims,
   input  logic                  req_valid,
   input  mf3_pkg::pixel_type    req_pixel,
   output logic                  req_ready,
   input  logic                  issue_ok,
   output logic                  job_valid,
   output mf3_pkg::job_type      job
);

   // input position
   logic [mf3_pkg::COL_BITS-1:0] in_column_ff, in_column_in;
   logic [mf3_pkg::ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [mf3_pkg::DIM_BITS-1:0] width_eff, height_eff;
   logic                         row_end, last_row, accept;

   // stage waiting for line store data
   logic                          s1_valid_ff, s1_valid_in;
   mf3_pkg::pixel_type            s1_pixel_ff;
   logic [mf3_pkg::COL_BITS-1:0]  s1_col_ff;
   logic [mf3_pkg::ROW_BITS-1:0]  s1_row_ff;
   logic                          s1_row_end_ff, s1_last_row_ff;
   logic                          s1_fwd_ff, s1_fwd_in;
   logic [mf3_pkg::LINE_BITS-1:0] s1_fwd_data_ff;
   logic [mf3_pkg::LINE_BITS-1:0] ram_rd_data, line_data, wr_data;
   mf3_pkg::pixel_type            older_pix, newer_pix;
   logic                          s1_move;

   // window and sequencer
   mf3_pkg::pixel_type              win_ff [mf3_pkg::WIN_SIZE];
   logic [mf3_pkg::MAX_RESULTS-1:0] pend_ff, pend_in, pend_new, remaining;
   logic [mf3_pkg::ROW_BITS-1:0]    seq_row_ff;
   logic [mf3_pkg::COL_BITS-1:0]    seq_col_ff;
   logic [mf3_pkg::SEL_BITS-1:0]    sel;
   logic                            issue, last_one, load_ok;
   logic                            cr_two, cc_two;
   logic [2:0]                      row_in_bounds, col_in_bounds;

   assign width_eff  = mf3_pkg::clamp_dim(dims.width, mf3_pkg::DIM_BITS'(mf3_pkg::MAX_WIDTH));
   assign height_eff = mf3_pkg::clamp_dim(dims.height,
                                          mf3_pkg::DIM_BITS'(mf3_pkg::MAX_HEIGHT));
   assign row_end  = (mf3_pkg::DIM_BITS'(in_column_ff) + 1'b1) >= width_eff;
   assign last_row = (mf3_pkg::DIM_BITS'(in_row_ff) + 1'b1) >= height_eff;

   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      if (accept) begin
         if (row_end) begin
            in_column_in = '0;
            in_row_in    = last_row ? '0 : in_row_ff + 1'b1;
         end else begin
            in_column_in = in_column_ff + 1'b1;
         end
      end
   end

   mf3_ram #(
      .WIDTH (mf3_pkg::LINE_BITS),
      .DEPTH (mf3_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff[mf3_pkg::ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (in_column_ff[mf3_pkg::ADDR_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // same entry written at the edge it was read
   assign line_data = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign older_pix = line_data[mf3_pkg::LINE_BITS-1:mf3_pkg::PIXEL_BITS];
   assign newer_pix = line_data[mf3_pkg::PIXEL_BITS-1:0];
   assign wr_data   = {newer_pix, s1_pixel_ff};
   assign s1_move   = s1_valid_ff && load_ok;
   assign s1_fwd_in = s1_move && (s1_col_ff == in_column_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_pixel;
         s1_col_ff      <= in_column_ff;
         s1_row_ff      <= in_row_ff;
         s1_row_end_ff  <= row_end;
         s1_last_row_ff <= last_row;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   // results released by the pixel entering the window
   always_comb begin
      pend_new = '0;
      pend_new[mf3_pkg::RES_UP_LEFT] = (s1_row_ff != '0) && (s1_col_ff != '0);
      pend_new[mf3_pkg::RES_UP]      = (s1_row_ff != '0) && s1_row_end_ff;
      pend_new[mf3_pkg::RES_LEFT]    = s1_last_row_ff && (s1_col_ff != '0);
      pend_new[mf3_pkg::RES_HERE]    = s1_last_row_ff && s1_row_end_ff;
   end

   always_comb begin
      if (pend_ff[mf3_pkg::RES_UP_LEFT]) begin
         sel = mf3_pkg::RES_UP_LEFT;
      end else if (pend_ff[mf3_pkg::RES_UP]) begin
         sel = mf3_pkg::RES_UP;
      end else if (pend_ff[mf3_pkg::RES_LEFT]) begin
         sel = mf3_pkg::RES_LEFT;
      end else begin
         sel = mf3_pkg::RES_HERE;
      end
   end

   assign remaining = pend_ff & ~(mf3_pkg::MAX_RESULTS'(1) << sel);
   assign last_one  = (remaining == '0);
   assign issue     = (pend_ff != '0) && issue_ok;
   assign load_ok   = (pend_ff == '0) || (issue && last_one);

   always_comb begin
      pend_in = pend_ff;
      if (s1_move) begin
         pend_in = pend_new;
      end else if (issue) begin
         pend_in = remaining;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int k = 0; k < mf3_pkg::WIN_SIZE; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         pend_ff <= pend_in;
         if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3]     <= win_ff[i*3 + 1];
               win_ff[i*3 + 1] <= win_ff[i*3 + 2];
            end
            win_ff[2] <= older_pix;
            win_ff[5] <= newer_pix;
            win_ff[8] <= s1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         seq_row_ff <= s1_row_ff;
         seq_col_ff <= s1_col_ff;
      end
   end

   // neighborhood of the selected result
   assign cr_two = (sel == mf3_pkg::RES_LEFT) || (sel == mf3_pkg::RES_HERE);
   assign cc_two = (sel == mf3_pkg::RES_UP) || (sel == mf3_pkg::RES_HERE);

   assign row_in_bounds[0] = !cr_two && (seq_row_ff >= mf3_pkg::ROW_BITS'(2));
   assign row_in_bounds[1] = (seq_row_ff != '0);
   assign row_in_bounds[2] = 1'b1;
   assign col_in_bounds[0] = !cc_two && (seq_col_ff >= mf3_pkg::COL_BITS'(2));
   assign col_in_bounds[1] = (seq_col_ff != '0);
   assign col_in_bounds[2] = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            job.vals[i*3 + j] = win_ff[i*3 + j];
            job.mask[i*3 + j] = row_in_bounds[i] && col_in_bounds[j];
         end
      end
      job.tag.row  = cr_two ? seq_row_ff : seq_row_ff - 1'b1;
      job.tag.col  = cc_two ? seq_col_ff : seq_col_ff - 1'b1;
      job.tag.last = last_one;
      job.tag.eof  = (sel == mf3_pkg::RES_HERE);
   end

   assign job_valid = issue;

endmodule

>>> rtl/core/mf3_median.sv
// three-stage rank-select median of the masked window
module mf3_median (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  mf3_pkg::job_type       in_job,
   output logic                   out_valid,
   output mf3_pkg::result_type    out_result
);

   logic                              p0_valid_ff, p1_valid_ff, p2_valid_ff;
   mf3_pkg::job_type                  p0_job_ff;
   mf3_pkg::pixel_type [mf3_pkg::WIN_SIZE-1:0] p1_vals_ff, p2_vals_ff;
   logic [mf3_pkg::WIN_SIZE-1:0]      p1_mask_ff, p2_mask_ff;
   mf3_pkg::tag_type                  p1_tag_ff, p2_tag_ff;
   logic [mf3_pkg::WIN_SIZE-1:0]      lower_in [mf3_pkg::WIN_SIZE];
   logic [mf3_pkg::WIN_SIZE-1:0]      lower_ff [mf3_pkg::WIN_SIZE];
   logic [mf3_pkg::RANK_BITS-1:0]     rank_in [mf3_pkg::WIN_SIZE];
   logic [mf3_pkg::RANK_BITS-1:0]     rank_ff [mf3_pkg::WIN_SIZE];
   logic [mf3_pkg::RANK_BITS-1:0]     target_in, target_ff;
   mf3_pkg::pixel_type                median;

   // pairwise order, ties broken by position
   always_comb begin
      for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
         for (int j = 0; j < mf3_pkg::WIN_SIZE; j++) begin
            lower_in[i][j] = p0_job_ff.mask[j] &&
                             ((p0_job_ff.vals[j] < p0_job_ff.vals[i]) ||
                              ((p0_job_ff.vals[j] == p0_job_ff.vals[i]) && (j < i)));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
         rank_in[i] = mf3_pkg::count_ones(lower_ff[i]);
      end
      target_in = mf3_pkg::count_ones(p1_mask_ff) >> 1;
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
         if (p2_mask_ff[i] && (rank_ff[i] == target_ff)) begin
            median = median | p2_vals_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= in_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_job_ff  <= in_job;
      p1_vals_ff <= p0_job_ff.vals;
      p1_mask_ff <= p0_job_ff.mask;
      p1_tag_ff  <= p0_job_ff.tag;
      for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
         lower_ff[i] <= lower_in[i];
         rank_ff[i]  <= rank_in[i];
      end
      p2_vals_ff <= p1_vals_ff;
      p2_mask_ff <= p1_mask_ff;
      p2_tag_ff  <= p1_tag_ff;
      target_ff  <= target_in;
   end

   assign out_valid         = p2_valid_ff;
   assign out_result.median = median;
   assign out_result.tag    = p2_tag_ff;

endmodule

>>> rtl/core/mf3_outq.sv
// result queue with issue credits covering the median pipeline
module mf3_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue,
   output logic                   issue_ok,
   input  logic                   push,
   input  mf3_pkg::result_type    push_result,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mf3_pkg::result_type    rsp_result
);

   mf3_pkg::result_type               mem_ff [mf3_pkg::OUTQ_DEPTH];
   logic [mf3_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mf3_pkg::OUTQ_CNT_BITS-1:0] fill_ff, fill_in, occ_ff, occ_in;
   logic                              pop;

   assign rsp_valid  = (fill_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_result = mem_ff[rd_ptr_ff];
   assign issue_ok   = (occ_ff < mf3_pkg::OUTQ_CNT_BITS'(mf3_pkg::OUTQ_DEPTH));

   always_comb begin
      fill_in = fill_ff;
      occ_in  = occ_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
      if (issue && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!issue && pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         occ_ff    <= '0;
      end else begin
         fill_ff <= fill_in;
         occ_ff  <= occ_in;
         if (push) begin
            wr_ptr_ff <= mf3_pkg::OUTQ_PTR_BITS'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= mf3_pkg::OUTQ_PTR_BITS'(rd_ptr_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_result;
      end
   end

endmodule

>>> rtl/core/median_filter_3x3_shrinking_border_top.sv
// 3x3 median filter with shrinking border, top level
//
// Pixels enter in raster order and each output is the median of the in-bounds
// 3x3 neighborhood (1 to 9 values; upper median for even counts), tagged with
// its row and column. A pixel is taken every cycle as long as each pixel releases
// at most one result and the output queue has room; a pixel at the end of a row or in
// the last row releases up to four results, which leave the window one per cycle
// into the median pipeline while the queue has room, and the input holds meanwhile.
// The line store is one ram read on the pixel transfer and written back as the pixel
// enters the window, with forwarding when the next pixel reads the same column. An
// issued result passes the three median stages and the eight-entry output queue,
// which keeps the input flowing while results wait to be taken. Width and height are
// written through the register port while the block is idle, a rule the user must
// keep that the block does not enforce; 0 acts as 1 and values above 1024 act as 1024.
module median_filter_3x3_shrinking_border_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mf3_pkg::PIXEL_BITS-1:0]     req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mf3_pkg::PIXEL_BITS-1:0]     rsp_median_value,
   output logic [mf3_pkg::ROW_BITS-1:0]       rsp_out_row,
   output logic [mf3_pkg::COL_BITS-1:0]       rsp_out_col,
   output logic                               rsp_last_in_run,
   output logic                               rsp_end_of_frame,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mf3_pkg::PADDR_BITS-1:0]     paddr,
   input  logic [mf3_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [mf3_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   mf3_pkg::dims_type   dims;
   mf3_pkg::job_type    job;
   mf3_pkg::result_type med_result, rsp_result;
   logic                job_valid, issue_ok, med_valid;

   mf3_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dims    (dims)
   );

   mf3_frontend u_frontend (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .req_valid (req_valid),
      .req_pixel (req_pixel),
      .req_ready (req_ready),
      .issue_ok  (issue_ok),
      .job_valid (job_valid),
      .job       (job)
   );

   mf3_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (job_valid),
      .in_job     (job),
      .out_valid  (med_valid),
      .out_result (med_result)
   );

   mf3_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .issue       (job_valid),
      .issue_ok    (issue_ok),
      .push        (med_valid),
      .push_result (med_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_median_value = rsp_result.median;
   assign rsp_out_row      = rsp_result.tag.row;
   assign rsp_out_col      = rsp_result.tag.col;
   assign rsp_last_in_run  = rsp_result.tag.last;
   assign rsp_end_of_frame = rsp_result.tag.eof;

endmodule

>>> sim/tb_median_filter_3x3_shrinking_border_top.sv
// self-checking testbench for the 3x3 shrinking-border median filter
`timescale 1ns / 1ps

module tb_median_filter_3x3_shrinking_border_top;

   localparam int RANDOM_PIXELS = 150;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 200000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [mf3_pkg::PIXEL_BITS-1:0]      req_pixel = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [mf3_pkg::PIXEL_BITS-1:0]      rsp_median_value;
   logic [mf3_pkg::ROW_BITS-1:0]        rsp_out_row;
   logic [mf3_pkg::COL_BITS-1:0]        rsp_out_col;
   logic                                rsp_last_in_run;
   logic                                rsp_end_of_frame;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [mf3_pkg::PADDR_BITS-1:0]      paddr = '0;
   logic [mf3_pkg::CSR_DATA_BITS-1:0]   pwdata = '0;
   logic [mf3_pkg::CSR_DATA_BITS-1:0]   prdata;
   logic                                pready;

   median_filter_3x3_shrinking_border_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_value (rsp_median_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #6 clock = ~clock;

   mf3_pkg::pixel_type    pixel_queue [$];
   mf3_pkg::result_type   expected_medians [$];
   int                    pixels_taken = 0;
   int                    errors = 0;
   int                    cycle_count = 0;
   logic                  calm;

   // filter state as seen from outside
   logic [mf3_pkg::DIM_BITS-1:0]   width_setting = 11'd1024;
   logic [mf3_pkg::DIM_BITS-1:0]   height_setting = 11'd1024;
   bit [mf3_pkg::PIXEL_BITS-1:0]   older_line [mf3_pkg::MAX_WIDTH];
   bit [mf3_pkg::PIXEL_BITS-1:0]   newer_line [mf3_pkg::MAX_WIDTH];
   bit [mf3_pkg::PIXEL_BITS-1:0]   win [mf3_pkg::WIN_SIZE];
   int unsigned                    col_at = 0;
   int unsigned                    row_at = 0;

   assign calm = pixels_taken >= 70 && pixels_taken < 130;

   function automatic mf3_pkg::pixel_type window_median(input int cr, input int cc);
      bit [mf3_pkg::PIXEL_BITS-1:0] vals [mf3_pkg::WIN_SIZE];
      bit [mf3_pkg::PIXEL_BITS-1:0] v;
      int n;
      int k;
      n = 0;
      for (int i = cr - 1; i <= cr + 1 && i <= 2; i++) begin
         if (row_at + i < 2) continue;
         for (int j = cc - 1; j <= cc + 1 && j <= 2; j++) begin
            if (col_at + j < 2) continue;
            v = win[i * 3 + j];
            k = n;
            while (k > 0 && vals[k - 1] > v) begin
               vals[k] = vals[k - 1];
               k--;
            end
            vals[k] = v;
            n++;
         end
      end
      return vals[n / 2];
   endfunction

   function automatic void filter_pixel(input mf3_pkg::pixel_type px);
      int unsigned          w;
      int unsigned          h;
      bit                   row_end;
      bit                   last_row;
      bit [3:0]             released;
      int                   last_k;
      int                   cr;
      int                   cc;
      mf3_pkg::result_type  res;
      w = width_setting == 0 ? 1 :
          (width_setting > mf3_pkg::MAX_WIDTH ? mf3_pkg::MAX_WIDTH : width_setting);
      h = height_setting == 0 ? 1 :
          (height_setting > mf3_pkg::MAX_HEIGHT ? mf3_pkg::MAX_HEIGHT : height_setting);
      row_end  = col_at + 1 >= w;
      last_row = row_at + 1 >= h;
      for (int i = 0; i < 3; i++) begin
         win[i * 3]     = win[i * 3 + 1];
         win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = older_line[col_at];
      win[5] = newer_line[col_at];
      win[8] = px;
      older_line[col_at] = newer_line[col_at];
      newer_line[col_at] = px;
      released[mf3_pkg::RES_UP_LEFT] = row_at >= 1 && col_at >= 1;
      released[mf3_pkg::RES_UP]      = row_at >= 1 && row_end;
      released[mf3_pkg::RES_LEFT]    = last_row && col_at >= 1;
      released[mf3_pkg::RES_HERE]    = last_row && row_end;
      last_k = -1;
      for (int k = 0; k < mf3_pkg::MAX_RESULTS; k++) begin
         if (released[k]) last_k = k;
      end
      for (int k = 0; k < mf3_pkg::MAX_RESULTS; k++) begin
         if (!released[k]) continue;
         cr = k >= mf3_pkg::RES_LEFT ? 2 : 1;
         cc = (k == mf3_pkg::RES_UP || k == mf3_pkg::RES_HERE) ? 2 : 1;
         res.median   = window_median(cr, cc);
         res.tag.row  = mf3_pkg::ROW_BITS'(row_at + cr - 2);
         res.tag.col  = mf3_pkg::COL_BITS'(col_at + cc - 2);
         res.tag.last = k == last_k;
         res.tag.eof  = k == mf3_pkg::RES_HERE;
         expected_medians.push_back(res);
      end
      if (row_end) begin
         col_at = 0;
         row_at = last_row ? 0 : row_at + 1;
      end else begin
         col_at++;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic check_transfer();
      mf3_pkg::result_type want;
      if (expected_medians.size() == 0) begin
         report_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                   rsp_out_row, rsp_out_col));
         return;
      end
      want = expected_medians.pop_front();
      if (rsp_median_value !== want.median)
         report_mismatch($sformatf("median %0d, expected %0d at row %0d col %0d",
                                   rsp_median_value, want.median, want.tag.row, want.tag.col));
      if (rsp_out_row !== want.tag.row)
         report_mismatch($sformatf("row %0d, expected %0d", rsp_out_row, want.tag.row));
      if (rsp_out_col !== want.tag.col)
         report_mismatch($sformatf("col %0d, expected %0d", rsp_out_col, want.tag.col));
      if (rsp_last_in_run !== want.tag.last)
         report_mismatch($sformatf("last_in_run %0b, expected %0b at row %0d col %0d",
                                   rsp_last_in_run, want.tag.last, want.tag.row, want.tag.col));
      if (rsp_end_of_frame !== want.tag.eof)
         report_mismatch($sformatf("end_of_frame %0b, expected %0b at row %0d col %0d",
                                   rsp_end_of_frame, want.tag.eof, want.tag.row, want.tag.col));
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filter_pixel(req_pixel);
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
               req_valid <= 1'b1;
               req_pixel <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_transfer();
         rsp_ready <= calm || $urandom_range(99) >= 9;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pixel_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mf3_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [mf3_pkg::DIM_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {21'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == mf3_pkg::REG_WIDTH) begin
         width_setting = value;
      end else begin
         height_setting = value;
      end
   endtask

   task automatic queue_pixels(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(7);
         pixel_queue.push_back(pick == 0 ? 8'd0 : pick == 1 ? 8'd255 : 8'($urandom_range(255)));
      end
   endtask

   initial begin
      int random_count;
      int pick;
      int frame_w;
      int frame_h;
      int eff_w;
      int eff_h;
      bit tall;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full 3x3 frame: corners, edges and the center
      write_reg(mf3_pkg::REG_WIDTH, 11'd3);
      write_reg(mf3_pkg::REG_HEIGHT, 11'd3);
      pixel_queue = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd128, 8'd1, 8'd255, 8'd0, 8'd99};
      wait_idle();

      // zero sizes act as one
      write_reg(mf3_pkg::REG_WIDTH, 11'd0);
      write_reg(mf3_pkg::REG_HEIGHT, 11'd2);
      pixel_queue = '{8'd170, 8'd85};
      wait_idle();
      write_reg(mf3_pkg::REG_WIDTH, 11'd2);
      write_reg(mf3_pkg::REG_HEIGHT, 11'd0);
      pixel_queue = '{8'd255, 8'd254};
      wait_idle();

      // oversize width, then shrink width and height in the middle of the frame
      write_reg(mf3_pkg::REG_WIDTH, 11'd2047);
      write_reg(mf3_pkg::REG_HEIGHT, 11'd1024);
      pixel_queue = '{8'd10, 8'd240, 8'd30, 8'd220, 8'd50, 8'd200};
      wait_idle();
      write_reg(mf3_pkg::REG_WIDTH, 11'd3);
      pixel_queue = '{8'd77};
      wait_idle();
      write_reg(mf3_pkg::REG_HEIGHT, 11'd0);
      pixel_queue = '{8'd255, 8'd0, 8'd128};
      wait_idle();

      // random whole frames, some with a tall height cut short on the last row
      random_count = 0;
      while (random_count < RANDOM_PIXELS) begin
         pick = $urandom_range(9);
         frame_w = pick < 7 ? $urandom_range(1, 6) : pick < 9 ? $urandom_range(7, 16) : 0;
         eff_w = frame_w == 0 ? 1 : frame_w;
         frame_h = $urandom_range(0, 5);
         eff_h = frame_h == 0 ? 1 : frame_h;
         tall = $urandom_range(3) == 0;
         write_reg(mf3_pkg::REG_WIDTH, mf3_pkg::DIM_BITS'(frame_w));
         write_reg(mf3_pkg::REG_HEIGHT, tall ? mf3_pkg::DIM_BITS'($urandom_range(1025, 2047))
                                             : mf3_pkg::DIM_BITS'(frame_h));
         if (tall) begin
            queue_pixels((eff_h - 1) * eff_w);
            wait_idle();
            write_reg(mf3_pkg::REG_HEIGHT, mf3_pkg::DIM_BITS'($urandom_range(0, eff_h)));
            queue_pixels(eff_w);
         end else begin
            queue_pixels(eff_w * eff_h);
         end
         random_count += eff_w * eff_h;
         wait_idle();
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> median_filter_3x3_shrinking_border_top.f
rtl/core/mf3_pkg.sv
rtl/core/mf3_ram.sv
rtl/core/mf3_csr.sv
rtl/core/mf3_frontend.sv
rtl/core/mf3_median.sv
rtl/core/mf3_outq.sv
rtl/core/median_filter_3x3_shrinking_border_top.sv
sim/tb_median_filter_3x3_shrinking_border_top.sv
